// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;

  localparam int MAX_BLOCKS = 1024;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int ROWS   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = ROW_W + BIT_W;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 17;
  localparam int COUNT_W   = 11;
  localparam int BYTES_W   = 27;
  localparam int PROD_W    = CNT_W + SIZE_W;
  localparam int SIZE_MAX  = 65536;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

endpackage

// ===== rtl/core/bba_div.sv =====
module bba_div
  import bba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ADDR_W-1:0]   dividend,
  input  logic [SIZE_W-1:0]   divisor,
  output logic                done,
  output logic [ADDR_W-1:0]   quotient
);

  logic              running;
  logic [5:0]        step;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]   trial;
  logic              take;

  // restoring divide, one quotient bit per cycle, msb first
  assign trial = {rem, quotient[ADDR_W-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        rem      <= take ? SIZE_W'(trial - {1'b0, dvs}) : SIZE_W'(trial);
        quotient <= {quotient[ADDR_W-2:0], take};
        step     <= step + 6'd1;
        if (step == 6'(ADDR_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/bitmap_block_allocator_unit.sv =====
// Fixed-size block allocator. An allocate makes one pass over the bitmap
// memory (one 32-bit row per cycle, MAX_BLOCKS/32 rows), then the update
// (S_WR), the shared multiplier (S_MULA, S_MULB) and the result (S_OUT),
// and the next item can be taken at the edge that takes its result. A free
// first does the bit-serial divide of the offset by the block size, and
// then the same pass over the bitmap, the update, multiply and result.
// busy is high for the whole request and the next item is taken only once it
// drops. Each item gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall it, so it must take the result in that
// cycle. The bitmap needs no clearing pass after reset: a row that was never
// written reads as all free. Configuration writes are taken at any time
// (cfg_ready is always high) but belong in idle periods only.
module bitmap_block_allocator_unit
  import bba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [ADDR_W-1:0]    free_address,
  output logic                 done,
  output logic [1:0]           status,
  output logic [ADDR_W-1:0]    block_address,
  output logic [BYTES_W-1:0]   used_bytes,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_MULA = 3'd4;
  localparam logic [2:0] S_MULB = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  function automatic logic [BIT_W:0] pop_count(input logic [WORD_W-1:0] w);
    logic [BIT_W:0] c;
    c = '0;
    for (int b = 0; b < WORD_W; b++) c = c + (BIT_W + 1)'(w[b]);
    return c;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (w[b]) p = BIT_W'(b);
    end
    return p;
  endfunction

  // configuration
  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  block_size;
  logic [COUNT_W-1:0] block_count;
  logic [SIZE_W-1:0]  bs_eff;
  logic [CNT_W-1:0]   n_eff;

  // control
  logic [2:0]       state;
  logic             req_r;
  logic [ADDR_W-1:0] addr_r;
  logic             in_range;
  logic [IDX_W-1:0] tgt_idx;

  // scan
  logic [ROW_W:0]      issue_row;
  logic                pend;
  logic [ROW_W-1:0]    prow;
  logic [CNT_W-1:0]    cnt;
  logic                found;
  logic [ROW_W-1:0]    found_row;
  logic [BIT_W-1:0]    found_bit;
  logic [WORD_W-1:0]   found_word;
  logic [WORD_W-1:0]   tgt_word;
  logic [WORD_W-1:0]   row_word;
  logic [WORD_W-1:0]   row_mask;
  logic [WORD_W-1:0]   used_bits;
  logic [WORD_W-1:0]   free_bits;

  // bitmap memory
  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   row_vld;
  logic [ROW_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              rd_vld;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  // shared multiplier and result
  logic [CNT_W-1:0]  mul_a;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] addr_out;

  // divider
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_q;

  logic alloc_ok;
  logic free_ok;

  assign cfg_ready = 1'b1;
  assign busy      = state != S_IDLE;

  assign bs_eff = (block_size == '0) ? SIZE_W'(1) :
                  (32'(block_size) > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : block_size;
  assign n_eff  = (32'(block_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) :
                  CNT_W'(block_count);

  assign alloc_ok = (req_r == REQ_ALLOC) && found;
  assign free_ok  = (req_r == REQ_FREE) && in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      block_size   <= SIZE_W'(64);
      block_count  <= COUNT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE:  base_address <= cfg_data;
        REG_SIZE:  block_size   <= cfg_data[SIZE_W-1:0];
        REG_COUNT: block_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  bba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (addr_r - base_address),
    .divisor  (bs_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  assign rd_addr = issue_row[ROW_W-1:0];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = found_row;
    wr_data = found_word | (WORD_W'(1) << found_bit);
    if (state == S_WR) begin
      if (alloc_ok) begin
        wr_en = 1'b1;
      end else if (free_ok) begin
        wr_en   = 1'b1;
        wr_addr = tgt_idx[IDX_W-1:BIT_W];
        wr_data = tgt_word & ~(WORD_W'(1) << tgt_idx[BIT_W-1:0]);
      end
    end
  end

  // a row never written reads as all free
  assign row_word = rd_vld ? rd_data : '0;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      row_mask[b] = 32'({prow, BIT_W'(b)}) < 32'(n_eff);
    end
  end

  assign used_bits = row_word & row_mask;
  assign free_bits = ~row_word & row_mask;

  always_comb begin
    case (state)
      S_MULA:  mul_a = CNT_W'({found_row, found_bit});
      default: mul_a = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
      pend      <= 1'b0;
      row_vld   <= '0;
      rd_vld    <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      rd_vld    <= row_vld[rd_addr];
      if (wr_en) row_vld[wr_addr] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_r     <= req_type;
            addr_r    <= free_address;
            issue_row <= '0;
            pend      <= 1'b0;
            cnt       <= '0;
            found     <= 1'b0;
            in_range  <= 1'b0;
            tgt_idx   <= '0;
            if (req_type == REQ_FREE) begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            in_range <= div_q < ADDR_W'(n_eff);
            tgt_idx  <= div_q[IDX_W-1:0];
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue_row != (ROW_W + 1)'(ROWS)) begin
            issue_row <= issue_row + (ROW_W + 1)'(1);
            prow      <= issue_row[ROW_W-1:0];
            pend      <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            cnt <= cnt + CNT_W'(pop_count(used_bits));
            if (!found && (free_bits != '0)) begin
              found      <= 1'b1;
              found_row  <= prow;
              found_bit  <= lowest_set(free_bits);
              found_word <= row_word;
            end
            if (prow == tgt_idx[IDX_W-1:BIT_W]) tgt_word <= row_word;
          end
          if (issue_row == (ROW_W + 1)'(ROWS) && !pend) state <= S_WR;
        end
        S_WR: begin
          if (alloc_ok) begin
            cnt <= cnt + CNT_W'(1);
          end else if (free_ok && tgt_word[tgt_idx[BIT_W-1:0]]) begin
            cnt <= cnt - CNT_W'(1);
          end
          state <= S_MULA;
        end
        S_MULA: begin
          prod  <= PROD_W'(mul_a) * PROD_W'(bs_eff);
          state <= S_MULB;
        end
        S_MULB: begin
          addr_out <= base_address + ADDR_W'(prod);
          prod     <= PROD_W'(mul_a) * PROD_W'(bs_eff);
          state    <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          if (req_r == REQ_ALLOC) begin
            status        <= found ? ST_ALLOCATED : ST_FULL;
            block_address <= found ? addr_out : '0;
          end else begin
            status        <= in_range ? ST_FREED : ST_RANGE;
            block_address <= '0;
          end
          used_bytes <= (prod > PROD_W'({BYTES_W{1'b1}})) ? {BYTES_W{1'b1}} :
                        prod[BYTES_W-1:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bba_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 104;

  typedef enum logic [2:0] {
    K_ALLOC,
    K_FREE_AT,
    K_FREE_USED,
    K_FREE_ANY,
    K_FREE_ABOVE,
    K_FREE_RAW
  } req_kind_t;

  typedef struct {
    req_kind_t   kind;
    int          idx;
    int          off;
    logic [31:0] raw;
  } alloc_req_t;

  typedef struct {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  block_address;
    logic [BYTES_W-1:0] used_bytes;
  } outcome_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic req_type = REQ_ALLOC;
  logic [ADDR_W-1:0] free_address = '0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BASE;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic [ADDR_W-1:0] block_address;
  logic [BYTES_W-1:0] used_bytes;
  logic cfg_ready;

  bitmap_block_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .free_address(free_address),
    .done(done),
    .status(status),
    .block_address(block_address),
    .used_bytes(used_bytes),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow allocator state
  logic [MAX_BLOCKS-1:0] block_used = '0;
  logic [ADDR_W-1:0] region_base = '0;
  logic [SIZE_W-1:0] region_bsize = 17'd64;
  logic [COUNT_W-1:0] region_count = 11'd1024;

  alloc_req_t requests_todo[$];
  outcome_t outcomes_due[$];
  alloc_req_t next_req;
  outcome_t seen;
  int gap_pct = 33;
  int errors = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int block_bytes();
    if (region_bsize == 0) return 1;
    if (region_bsize > SIZE_MAX) return SIZE_MAX;
    return int'(region_bsize);
  endfunction

  function automatic int live_blocks();
    if (region_count > MAX_BLOCKS) return MAX_BLOCKS;
    return int'(region_count);
  endfunction

  // allocate or free on the shadow bitmap and queue the outcome
  task automatic apply_request(input logic kind, input logic [ADDR_W-1:0] addr);
    outcome_t o;
    int bs;
    int n;
    int used;
    logic hit;
    logic [31:0] idx;
    longint prod;
    bs = block_bytes();
    n = live_blocks();
    o.block_address = '0;
    hit = 1'b0;
    if (kind == REQ_ALLOC) begin
      o.status = ST_FULL;
      for (int i = 0; i < n && !hit; i++) begin
        if (!block_used[i]) begin
          block_used[i] = 1'b1;
          o.block_address = region_base + 32'(i * bs);
          o.status = ST_ALLOCATED;
          hit = 1'b1;
        end
      end
    end else begin
      idx = (addr - region_base) / 32'(bs);
      if (idx < 32'(n)) begin
        block_used[idx] = 1'b0;
        o.status = ST_FREED;
      end else begin
        o.status = ST_RANGE;
      end
    end
    used = 0;
    for (int i = 0; i < n; i++) used += block_used[i];
    prod = longint'(used) * bs;
    if (prod > longint'({BYTES_W{1'b1}})) prod = longint'({BYTES_W{1'b1}});
    o.used_bytes = prod[BYTES_W-1:0];
    outcomes_due.push_back(o);
  endtask

  // pick the address of a free item against the current shadow state
  function automatic logic [ADDR_W-1:0] free_target(alloc_req_t r);
    int bs;
    int n;
    int idx;
    int off;
    int taken[$];
    bs = block_bytes();
    n = live_blocks();
    idx = r.idx;
    off = ($urandom_range(1, 0) == 1) ? int'($urandom_range(bs - 1, 0)) : 0;
    case (r.kind)
      K_FREE_AT: off = r.off;
      K_FREE_USED: begin
        for (int i = 0; i < n; i++) if (block_used[i]) taken.push_back(i);
        idx = (taken.size() == 0) ? 0 : taken[$urandom_range(taken.size() - 1, 0)];
      end
      K_FREE_ANY: idx = (n == 0) ? 0 : int'($urandom_range(n - 1, 0));
      K_FREE_ABOVE: idx = n + int'($urandom_range(3, 0));
      default: return r.raw;
    endcase
    return region_base + 32'(idx * bs + off);
  endfunction

  // driver: predicts at acceptance, then offers the next item
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_request(req_type, free_address);
      if (!start || !busy) begin
        if (requests_todo.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
          next_req = requests_todo.pop_front();
          start <= 1'b1;
          req_type <= (next_req.kind == K_ALLOC) ? REQ_ALLOC : REQ_FREE;
          free_address <= (next_req.kind == K_ALLOC) ? $urandom : free_target(next_req);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        errors++;
        $display("%0t unexpected item: status %0d addr %h bytes %0d", $time,
                 status, block_address, used_bytes);
      end else begin
        seen = outcomes_due.pop_front();
        if (status !== seen.status) begin
          errors++;
          $display("%0t status: expected %0d actual %0d", $time, seen.status, status);
        end
        if (block_address !== seen.block_address) begin
          errors++;
          $display("%0t block_address: expected %h actual %h", $time,
                   seen.block_address, block_address);
        end
        if (used_bytes !== seen.used_bytes) begin
          errors++;
          $display("%0t used_bytes: expected %0d actual %0d", $time,
                   seen.used_bytes, used_bytes);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_req(input req_kind_t kind, input int idx, input int off,
                          input logic [31:0] raw);
    alloc_req_t r;
    r.kind = kind;
    r.idx = idx;
    r.off = off;
    r.raw = raw;
    requests_todo.push_back(r);
  endtask

  task automatic push_random();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 50) push_req(K_ALLOC, 0, 0, '0);
    else if (pick < 78) push_req(K_FREE_USED, 0, 0, '0);
    else if (pick < 88) push_req(K_FREE_ANY, 0, 0, '0);
    else if (pick < 94) push_req(K_FREE_ABOVE, 0, 0, '0);
    else push_req(K_FREE_RAW, 0, 0, $urandom);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (requests_todo.size() != 0 || start || outcomes_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BASE:  region_base = data;
      REG_SIZE:  region_bsize = data[SIZE_W-1:0];
      REG_COUNT: region_count = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] bsize,
                           input logic [31:0] count);
    cfg_write(REG_BASE, base);
    cfg_write(REG_SIZE, bsize);
    cfg_write(REG_COUNT, count);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: lowest free block, double free, unaligned, range edge
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_FREE_AT, 1, 0, '0);
    push_req(K_FREE_AT, 1, 0, '0);
    push_req(K_FREE_AT, 0, 63, '0);
    push_req(K_FREE_RAW, 0, 0, 32'hFFFF_FFFF);
    push_req(K_FREE_RAW, 0, 0, 32'h0001_0000);
    push_req(K_ALLOC, 0, 0, '0);
    settle();

    // size zero acts as one, count masked to 3, address wraps past 2^32
    configure(32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_F803);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_FREE_RAW, 0, 0, 32'h0000_0000);
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_FREE_RAW, 0, 0, 32'hFFFF_FFFD);
    settle();

    // oversized size and count saturate
    configure(32'h0000_0000, 32'h0001_FFFF, 32'h0000_07FF);
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_FREE_AT, 1023, 65535, '0);
    push_req(K_FREE_RAW, 0, 0, 32'hFFFF_FFFF);
    settle();

    // no blocks at all
    cfg_write(REG_COUNT, 32'd0);
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_FREE_AT, 0, 0, '0);
    settle();

    // lowered count hides used blocks above it
    cfg_write(REG_COUNT, 32'd2);
    push_req(K_ALLOC, 0, 0, '0);
    push_req(K_FREE_AT, 3, 0, '0);
    push_req(K_FREE_AT, 1, 7, '0);
    push_req(K_ALLOC, 0, 0, '0);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      gap_pct = (p < 3) ? 33 : (p < 6) ? 49 : 0;
      case (p)
        1, 5: configure($urandom, $urandom, $urandom);
        2: configure($urandom, SIZE_MAX, MAX_BLOCKS);
        3: configure(32'h0000_0000, 32'd1, 32'd1);
        6: configure($urandom, $urandom_range(8, 1), $urandom_range(64, 30));
        7: begin
          configure(32'hFFFF_FFFF, SIZE_MAX, 32'd8);
          cfg_write(REG_SPARE, $urandom);
        end
        default: configure($urandom, $urandom_range(512, 1), $urandom_range(24, 1));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) push_random();
      settle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== bitmap_block_allocator_unit.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_div.sv
rtl/core/bitmap_block_allocator_unit.sv
tb/tb_top.sv
